>>> rtl/core/nes_pkg.sv
// Shared types and constants for the nearest embedding search block.
// Depends on nothing; imported by nes_datapath and nearest_embedding_search.
package nes_pkg;

  localparam int ELEMENT_BITS = 16;
  localparam int ENTRY_W      = 10;
  localparam int POS_W        = 9;
  localparam int DIST_W       = 41;
  localparam int SUM_W        = 42;
  localparam int SQ_W         = 2 * ELEMENT_BITS;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;
  localparam int ENT_CFG_W    = 11;
  localparam int LEN_CFG_W    = 10;

  localparam logic [CFG_IDX_W-1:0] REG_ENTRIES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH  = 2'd1;

  localparam logic [ENT_CFG_W-1:0] ENTRIES_RST = 11'd1;
  localparam logic [LEN_CFG_W-1:0] LENGTH_RST  = 10'd512;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e                           cmd;
    logic [ENTRY_W-1:0]             entry;
    logic [POS_W-1:0]               position;
    logic signed [ELEMENT_BITS-1:0] value;
    logic                           last;
  } item_t;

  typedef struct packed {
    logic [DIST_W-1:0]  best_distance;
    logic [ENTRY_W-1:0] best_entry;
  } result_t;

  // control that travels with each element pair through the datapath
  typedef struct packed {
    logic               vld;
    logic               first;
    logic               row_end;
    logic               first_row;
    logic               fin;
    logic [ENTRY_W-1:0] entry;
  } tag_t;

endpackage

>>> rtl/core/nes_datapath.sv
// Difference, square, accumulate and best-match stages of the search.
// Depends on nes_pkg; fed one element pair per cycle by nearest_embedding_search.
module nes_datapath import nes_pkg::*; (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  tag_t                           tag_i,
  input  logic signed [ELEMENT_BITS-1:0] query_i,
  input  logic signed [ELEMENT_BITS-1:0] gallery_i,
  output result_t                        best_o,
  output logic                           done_o
);

  tag_t                           tag2_q, tag3_q, tag4_q;
  logic signed [ELEMENT_BITS:0]   diff_d, diff_q;
  logic signed [2*ELEMENT_BITS+1:0] prod;
  logic [SQ_W-1:0]                sq_q;
  logic [SUM_W-1:0]               acc_d, acc_q;
  logic [SUM_W-1:0]               best_q;
  logic [ENTRY_W-1:0]             best_idx_q;
  logic                           done_q;

  assign diff_d = $signed({query_i[ELEMENT_BITS-1], query_i})
                - $signed({gallery_i[ELEMENT_BITS-1], gallery_i});
  assign prod   = diff_q * diff_q;
  assign acc_d  = tag3_q.first ? SUM_W'(sq_q) : acc_q + SUM_W'(sq_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag2_q     <= '0;
      tag3_q     <= '0;
      tag4_q     <= '0;
      acc_q      <= '0;
      best_q     <= '0;
      best_idx_q <= '0;
      done_q     <= 1'b0;
    end else begin
      tag2_q <= tag_i;
      tag3_q <= tag2_q;
      tag4_q <= tag3_q;
      done_q <= tag4_q.vld && tag4_q.fin;
      if (tag3_q.vld) begin
        acc_q <= acc_d;
      end
      if (tag4_q.vld && tag4_q.row_end) begin
        if (tag4_q.first_row || (acc_q < best_q)) begin
          best_q     <= acc_q;
          best_idx_q <= tag4_q.entry;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    diff_q <= diff_d;
    sq_q   <= prod[SQ_W-1:0];
  end

  assign best_o.best_distance = best_q[DIST_W-1:0];
  assign best_o.best_entry    = best_idx_q;
  assign done_o               = done_q;

endmodule

>>> rtl/core/nearest_embedding_search.sv
// Nearest embedding search top level: command port, config registers,
// gallery and query memories, sequencer. Depends on nes_pkg and nes_datapath.
//
// Usage:
//  - Command channel: item_i is taken at a rising edge with start_i high and
//    busy_o low. A load (cmd LOAD) writes one gallery element; a query element
//    (cmd QUERY) is stored at its position. Loads and queries stream in back
//    to back, one beat per cycle while busy_o is low.
//  - A query element with last set starts the search; busy_o is high from
//    the next cycle through the result strobe cycle.
//  - The search reads one gallery element and one query element per cycle
//    from the two memory read ports and runs them through one shared
//    subtract, multiply and accumulate pipe.
//  - result_valid_o is high for exactly one cycle with result_o; the receiver
//    cannot stall, so the result must be taken in that cycle.
//  - Config channel: cfg_ready_o is always high; write only while idle.
//  - Reset clears the sequencer, the registers (entries 1, length 512) and
//    the best-match state. Memory contents are undefined until written.
module nearest_embedding_search import nes_pkg::*; #(
  parameter int MAX_ENTRIES   = 1024,
  parameter int VECTOR_LENGTH = 512
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  item_t                 item_i,
  output logic                  result_valid_o,
  output result_t               result_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int EW     = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int LW     = (VECTOR_LENGTH > 1) ? $clog2(VECTOR_LENGTH) : 1;
  localparam int GDEPTH = 1 << (EW + LW);
  localparam int QDEPTH = 1 << LW;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_WAIT = 3'b100
  } state_e;

  state_e                         state_d, state_q;
  logic [ENT_CFG_W-1:0]           entries_q;
  logic [LEN_CFG_W-1:0]           length_q;
  logic [EW-1:0]                  e_d, e_q, e_last_d, e_last_q;
  logic [LW-1:0]                  p_d, p_q, p_last_d, p_last_q;
  logic [31:0]                    ent_c, len_c;
  logic                           accept, go, issue, row_end, fin;
  logic                           g_we, q_we;
  logic [EW+LW-1:0]               g_waddr;
  logic [LW-1:0]                  q_waddr;
  logic signed [ELEMENT_BITS-1:0] gmem [GDEPTH];
  logic signed [ELEMENT_BITS-1:0] qmem [QDEPTH];
  logic signed [ELEMENT_BITS-1:0] g_rd_q, q_rd_q;
  tag_t                           tag_d, tag1_q;
  logic                           dp_done;

  assign busy_o      = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i && !busy_o;
  assign go          = accept && (item_i.cmd == CMD_QUERY) && item_i.last;

  assign g_we    = accept && (item_i.cmd == CMD_LOAD)
                && (32'(item_i.entry) < 32'(MAX_ENTRIES))
                && (32'(item_i.position) < 32'(VECTOR_LENGTH));
  assign q_we    = accept && (item_i.cmd == CMD_QUERY)
                && (32'(item_i.position) < 32'(VECTOR_LENGTH));
  assign g_waddr = {EW'(item_i.entry), LW'(item_i.position)};
  assign q_waddr = LW'(item_i.position);

  // saturate the registers into their legal ranges at search start
  assign ent_c    = (entries_q == '0) ? 32'd1
                  : ((32'(entries_q) > 32'(MAX_ENTRIES)) ? 32'(MAX_ENTRIES)
                  : 32'(entries_q));
  assign len_c    = (length_q == '0) ? 32'd1
                  : ((32'(length_q) > 32'(VECTOR_LENGTH)) ? 32'(VECTOR_LENGTH)
                  : 32'(length_q));
  assign e_last_d = go ? EW'(ent_c - 32'd1) : e_last_q;
  assign p_last_d = go ? LW'(len_c - 32'd1) : p_last_q;

  assign issue   = (state_q == ST_RUN);
  assign row_end = (p_q == p_last_q);
  assign fin     = row_end && (e_q == e_last_q);

  always_comb begin
    state_d = state_q;
    e_d     = e_q;
    p_d     = p_q;
    case (state_q)
      ST_IDLE: begin
        if (go) begin
          state_d = ST_RUN;
          e_d     = '0;
          p_d     = '0;
        end
      end
      ST_RUN: begin
        if (row_end) begin
          p_d = '0;
          e_d = e_q + 1'b1;
          if (fin) begin
            state_d = ST_WAIT;
          end
        end else begin
          p_d = p_q + 1'b1;
        end
      end
      ST_WAIT: begin
        if (dp_done) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    tag_d           = '0;
    tag_d.vld       = issue;
    tag_d.first     = (p_q == '0);
    tag_d.row_end   = row_end;
    tag_d.first_row = (e_q == '0);
    tag_d.fin       = fin;
    tag_d.entry     = ENTRY_W'(e_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      entries_q <= ENTRIES_RST;
      length_q  <= LENGTH_RST;
      e_q       <= '0;
      p_q       <= '0;
      e_last_q  <= '0;
      p_last_q  <= '0;
      tag1_q    <= '0;
    end else begin
      state_q  <= state_d;
      e_q      <= e_d;
      p_q      <= p_d;
      e_last_q <= e_last_d;
      p_last_q <= p_last_d;
      tag1_q   <= tag_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_ENTRIES: entries_q <= cfg_data_i[ENT_CFG_W-1:0];
          REG_LENGTH:  length_q  <= cfg_data_i[LEN_CFG_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (g_we) begin
      gmem[g_waddr] <= item_i.value;
    end
    g_rd_q <= gmem[{e_q, p_q}];
  end

  always_ff @(posedge clk_i) begin
    if (q_we) begin
      qmem[q_waddr] <= item_i.value;
    end
    q_rd_q <= qmem[p_q];
  end

  nes_datapath u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .tag_i     (tag1_q),
    .query_i   (q_rd_q),
    .gallery_i (g_rd_q),
    .best_o    (result_o),
    .done_o    (dp_done)
  );

  assign result_valid_o = dp_done;

`ifndef SYNTHESIS
  a_go_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go |=> busy_o)
    else $error("search start did not raise busy");

  a_result_in_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> ($past(busy_o) && busy_o))
    else $error("result strobe outside a search");

  a_result_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (32'(result_o.best_entry) <= 32'(e_last_q)))
    else $error("best entry beyond entries searched");
`endif

endmodule
